### hdl/wtpd_pkg.sv
// Package: shared types and constants for the phase distortion wavetable oscillator.
package wtpd_pkg;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   localparam logic [1:0] REG_INCREMENT  = 2'd0;
   localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
   localparam logic [1:0] REG_DISTORTION = 2'd2;

   localparam logic [31:0] PD_BASE = 32'd214748365;
   localparam logic [31:0] PD_SPAN = 32'd3865470566;

   localparam logic [31:0] INCREMENT_RESET  = 32'd0;
   localparam logic [15:0] AMPLITUDE_RESET  = 16'd65535;
   localparam logic [15:0] DISTORTION_RESET = 16'd32768;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_KNEE  = 8'b00000010,
      ST_DIV   = 8'b00000100,
      ST_READ0 = 8'b00001000,
      ST_READ1 = 8'b00010000,
      ST_INTERP = 8'b00100000,
      ST_SCALE = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

endpackage

### hdl/wtpd_if.sv
// Interface: valid/ready channel carrying one payload word.
interface wtpd_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hdl/wtpd_ram.sv
// Generic single-port RAM with registered read.
module wtpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### hdl/wtpd_divider.sv
// Restoring divider: 32-bit quotient of a 63-bit dividend, one bit per cycle.
module wtpd_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] dividend,
   input  logic [32:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);
   logic [33:0] rem_ff, rem_in;
   logic [62:0] num_ff, num_in;
   logic [32:0] den_ff, den_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [33:0] trial;
   logic [33:0] shifted;

   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      shifted = {rem_ff[32:0], num_ff[62]};
      trial = shifted - {1'b0, den_ff};
      if (start) begin
         // upper 31 bits of the dividend are always below the divisor
         rem_in = {3'd0, dividend[62:32]};
         num_in = {dividend[31:0], 31'd0};
         den_in = divisor;
         quo_in = '0;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         num_in = {num_ff[61:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (!trial[33]) begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = (cnt_ff != 6'd0);
   assign quotient = quo_ff;
endmodule

### hdl/wavetable_oscillator_phase_distortion.sv
// Top level: phase distortion wavetable oscillator with APB register port.
// Tick words pass through knee, the bit-serial divider, two table reads,
// interpolation, gain multiply and output before the result is valid. Table
// write, stop and unused words go straight to output. One word is in flight at a
// time: a new word is accepted only once the previous result has been taken.
// Reset is synchronous and active high: phase and increment clear, amplitude full.
module wavetable_oscillator_phase_distortion
   import wtpd_pkg::*;
#(
   parameter int TABLE_WORDS = 2048,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   wtpd_if.sink        req,
   wtpd_if.source      rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(TABLE_WORDS);

   logic [31:0] inc_ff;
   logic [15:0] amp_ff, dist_ff;
   logic [31:0] phase_ff;
   state_type   state_ff;
   logic [1:0]  mode_ff;
   logic [31:0] pd_ff;
   logic        upper_ff;
   logic [31:0] bent_ff;
   logic [AW-1:0] ram_addr;
   logic          ram_we;
   logic [SAMPLE_BITS-1:0] ram_q;
   logic signed [SAMPLE_BITS-1:0] y0_ff;
   logic signed [SAMPLE_BITS+17:0] v_ff;
   logic        neg_ff;
   logic [31:0] gain_ff;
   logic [SAMPLE_BITS+48:0] prod_ff;
   logic [15:0] sample_ff;
   logic        rsp_valid_ff;
   logic        playing_ff;
   logic        div_start, div_busy;
   logic [31:0] div_q;
   logic [62:0] div_num;
   logic [32:0] div_den;
   logic [47:0] knee_prod;
   logic [AW-1:0] i0;
   logic [15:0] frac;
   logic        cfg_wr;
   logic signed [SAMPLE_BITS:0] dy;
   logic [SAMPLE_BITS+16:0] vabs;
   logic [31:0] bent_hi;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      case (csr_paddr[3:2])
         REG_INCREMENT:  csr_prdata = inc_ff;
         REG_AMPLITUDE:  csr_prdata = {16'd0, amp_ff};
         REG_DISTORTION: csr_prdata = {16'd0, dist_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload.sample = sample_ff;
   assign rsp.payload.playing = playing_ff;

   assign knee_prod = {32'd0, dist_ff} * {16'd0, PD_SPAN};
   assign div_start = (state_ff == ST_KNEE);
   assign div_num = upper_ff ? {32'(33'h100000000 - {1'b0, phase_ff}), 31'd0}
                             : {phase_ff, 31'd0};
   assign div_den = upper_ff ? (33'h100000000 - {1'b0, pd_ff}) : {1'b0, pd_ff};
   assign bent_hi = upper_ff ? (32'd0 - div_q) : div_q;

   // pos = bent * TABLE_WORDS (power of two)
   assign i0   = bent_ff[31 -: AW];
   assign frac = 16'((48'(bent_ff) << AW) >> 16);

   assign ram_we = req.valid && req.ready && (req.payload.mode == MODE_WRITE)
                   && ({5'd0, req.payload.table_address} < 16'(TABLE_WORDS));
   always_comb begin
      if (ram_we) begin
         ram_addr = AW'(req.payload.table_address);
      end else if (state_ff == ST_READ1) begin
         ram_addr = AW'(i0 + 1'b1);
      end else begin
         ram_addr = i0;
      end
   end

   wtpd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TABLE_WORDS)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(SAMPLE_BITS'(req.payload.table_value)), .rd_data(ram_q)
   );

   wtpd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .busy(div_busy), .quotient(div_q)
   );

   assign dy = $signed({ram_q[SAMPLE_BITS-1], ram_q}) - $signed({y0_ff[SAMPLE_BITS-1], y0_ff});
   assign vabs = v_ff[SAMPLE_BITS+17] ? (SAMPLE_BITS+17)'(-v_ff) : (SAMPLE_BITS+17)'(v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         inc_ff <= INCREMENT_RESET;
         amp_ff <= AMPLITUDE_RESET;
         dist_ff <= DISTORTION_RESET;
         phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
         playing_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            case (csr_paddr[3:2])
               REG_INCREMENT:  inc_ff <= csr_pwdata;
               REG_AMPLITUDE:  amp_ff <= csr_pwdata[15:0];
               REG_DISTORTION: dist_ff <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  mode_ff <= req.payload.mode;
                  pd_ff <= PD_BASE + knee_prod[47:16];
                  if (req.payload.mode == MODE_TICK) begin
                     state_ff <= ST_KNEE;
                  end else begin
                     if (req.payload.mode == MODE_STOP) begin
                        phase_ff <= '0;
                        inc_ff <= '0;
                     end
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_KNEE: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (!div_busy) begin
                  bent_ff <= bent_hi;
                  state_ff <= ST_READ0;
               end
            end
            ST_READ0: state_ff <= ST_READ1;
            ST_READ1: begin
               y0_ff <= $signed(ram_q);
               state_ff <= ST_INTERP;
            end
            ST_INTERP: begin
               v_ff <= ($signed({{2{y0_ff[SAMPLE_BITS-1]}}, y0_ff}) <<< 16)
                     + $signed({1'b0, frac}) * dy;
               gain_ff <= amp_ff * amp_ff;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               neg_ff <= v_ff[SAMPLE_BITS+17];
               prod_ff <= vabs * gain_ff;
               phase_ff <= phase_ff + inc_ff;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (mode_ff == MODE_TICK) begin
                  sample_ff <= neg_ff ? 16'(-(prod_ff >> 48)) : 16'(prod_ff >> 48);
               end else begin
                  sample_ff <= '0;
               end
               playing_ff <= (inc_ff != 32'd0);
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (state_ff == ST_IDLE) begin
         upper_ff <= phase_ff >= (PD_BASE + knee_prod[47:16]);
      end
   end

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE)) else $error("busy with result pending");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KNEE) |=> div_busy) else $error("divider did not start");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE)) else $error("table write while busy");
endmodule
